// File: sv/external_interrupt_edge_controller_core_assert.svh
// Assertion macros for the interrupt edge controller.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_CORE_ASSERT_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define EIEC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eiec assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EIEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eiec assertion failed");

`else

`define EIEC_ASSERT_IMPLY(lbl, ante, cons)
`define EIEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/eiec_pkg.sv
`default_nettype none

package eiec_pkg;

  // Fixed geometry of the line set and the pin bus.
  localparam int NUM_LINES  = 16;
  localparam int SEL_W      = 4;
  localparam int PIN_W      = 64;
  localparam int PIN_PORTS  = PIN_W / NUM_LINES;
  localparam int IRQ_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Item modes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Bus register selects.
  localparam logic [1:0] REG_MASK   = 2'd0;
  localparam logic [1:0] REG_SWTRIG = 2'd1;
  localparam logic [1:0] REG_PEND   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RISE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORTSEL = 2'd2;

  // Interrupt request grouping.
  localparam int          SINGLE_LINES = 5;
  localparam logic [15:0] GROUP_5_9    = 16'h03E0;
  localparam logic [15:0] GROUP_10_15  = 16'hFC00;

  typedef struct packed {
    logic [1:0]           mode;
    logic [1:0]           reg_select;
    logic [NUM_LINES-1:0] write_data;
    logic [PIN_W-1:0]     pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [NUM_LINES-1:0] read_data;
    logic [NUM_LINES-1:0] pending_lines;
    logic [IRQ_W-1:0]     irq_requests;
  } out_item_t;

  // Edge enables handed to the line logic.
  typedef struct packed {
    logic [NUM_LINES-1:0] rise;
    logic [NUM_LINES-1:0] fall;
  } edge_cfg_t;

  // Line state shown to the top level.
  typedef struct packed {
    logic [NUM_LINES-1:0] pending;
    logic [NUM_LINES-1:0] mask;
    logic [NUM_LINES-1:0] swtrig;
  } line_state_t;

endpackage

`default_nettype wire

// File: sv/eiec_sample.sv
`default_nettype none

module eiec_sample #(
  parameter int NUM_PORTS = 4
) (
  input  wire logic [eiec_pkg::NUM_LINES*eiec_pkg::SEL_W-1:0] port_select,
  input  wire logic [eiec_pkg::PIN_W-1:0]                     pin_levels,
  output logic      [eiec_pkg::NUM_LINES-1:0]                 levels
);
  import eiec_pkg::*;

  // Ports beyond the pin bus read as low, as do unpopulated ones.
  localparam int EffPorts = (NUM_PORTS < PIN_PORTS) ? NUM_PORTS : PIN_PORTS;
  localparam int PortIdxW = (PIN_PORTS > 1) ? $clog2(PIN_PORTS) : 1;

  // Each line picks its pin out of the column of ports at its position.
  for (genvar l = 0; l < NUM_LINES; l++) begin : g_line
    logic [SEL_W-1:0]     sel;
    logic [PIN_PORTS-1:0] col;

    assign sel = port_select[l*SEL_W +: SEL_W];

    for (genvar p = 0; p < PIN_PORTS; p++) begin : g_port
      assign col[p] = pin_levels[p*NUM_LINES + l];
    end

    assign levels[l] = (sel < SEL_W'(EffPorts)) && col[sel[PortIdxW-1:0]];
  end

endmodule

`default_nettype wire

// File: sv/eiec_core.sv
`default_nettype none

module eiec_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           fire,
  input  wire eiec_pkg::in_item_t             item,
  input  wire logic [eiec_pkg::NUM_LINES-1:0] levels_now,
  input  wire eiec_pkg::edge_cfg_t            edge_cfg,
  output eiec_pkg::out_item_t                 result,
  output eiec_pkg::line_state_t               state
);
  import eiec_pkg::*;

  logic [NUM_LINES-1:0] last_r, last_nxt;
  logic [NUM_LINES-1:0] pend_r, pend_nxt;
  logic [NUM_LINES-1:0] mask_r, mask_nxt;
  logic [NUM_LINES-1:0] soft_r, soft_nxt;
  logic [NUM_LINES-1:0] rise;
  logic [NUM_LINES-1:0] fall;
  logic [NUM_LINES-1:0] fresh;
  logic [NUM_LINES-1:0] rdata;
  logic [NUM_LINES-1:0] active;

  // Edge detection against the level kept from the previous tick.
  assign rise  = levels_now & ~last_r & edge_cfg.rise;
  assign fall  = last_r & ~levels_now & edge_cfg.fall;
  assign fresh = item.write_data & ~soft_r;

  // Next state and read data for the item in the input register.
  always_comb begin
    last_nxt = last_r;
    pend_nxt = pend_r;
    mask_nxt = mask_r;
    soft_nxt = soft_r;
    rdata    = '0;
    case (item.mode)
      MODE_TICK: begin
        pend_nxt = pend_r | rise | fall;
        last_nxt = levels_now;
      end
      MODE_WRITE: begin
        case (item.reg_select)
          REG_MASK: begin
            mask_nxt = item.write_data;
          end
          REG_SWTRIG: begin
            soft_nxt = soft_r | fresh;
            pend_nxt = pend_r | fresh;
          end
          REG_PEND: begin
            pend_nxt = pend_r & ~item.write_data;
            soft_nxt = soft_r & ~item.write_data;
          end
          default: begin
          end
        endcase
      end
      MODE_READ: begin
        case (item.reg_select)
          REG_MASK:   rdata = mask_r;
          REG_SWTRIG: rdata = soft_r;
          REG_PEND:   rdata = pend_r;
          default:    rdata = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  // Requests are formed from the state left by this item.
  assign active = pend_nxt & mask_nxt;

  assign result.read_data     = rdata;
  assign result.pending_lines = pend_nxt;
  assign result.irq_requests  = {|(active & GROUP_10_15), |(active & GROUP_5_9),
                                 active[SINGLE_LINES-1:0]};

  assign state.pending = pend_r;
  assign state.mask    = mask_r;
  assign state.swtrig  = soft_r;

  // State moves only when the item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      pend_r <= '0;
      mask_r <= '0;
      soft_r <= '0;
    end else if (fire) begin
      last_r <= last_nxt;
      pend_r <= pend_nxt;
      mask_r <= mask_nxt;
      soft_r <= soft_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/external_interrupt_edge_controller_core.sv
// External interrupt edge controller, sixteen lines.
//
// Input channel (in_valid, in_stall, in_data) carries one item per beat: a
// pin sample tick, a bus register write, or a bus register read. Every item
// gives exactly one result beat on the output channel (out_valid, out_stall,
// out_data) with read data, the pending bits and seven interrupt requests.
// The configuration port writes the edge enables and port selects; the user
// must write it only while no item is in flight; the block does not enforce it.
//
// An item lands in the input register, is evaluated and state-updated as it
// moves to the result register, and is shown there. Throughput is one item
// per cycle while the receiver does not stall; the update of the line state
// as each item moves on is what sets it. When the receiver stalls, the
// result register holds its beat and the input register can still take one
// more item; only when both are full is in_stall raised. Synchronous reset
// clears all line state, configuration and both valid flags.
`default_nettype none

module external_interrupt_edge_controller_core #(
  parameter int NUM_PORTS = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire eiec_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output eiec_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [eiec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [eiec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import eiec_pkg::*;

  logic                           s1_valid_r;
  in_item_t                       s1_item_r;
  logic                           out_valid_r;
  out_item_t                      out_data_r;
  logic                           s2_free;
  logic                           s1_move;
  logic                           in_take;
  logic [NUM_LINES-1:0]           rise_en_r;
  logic [NUM_LINES-1:0]           fall_en_r;
  logic [NUM_LINES*SEL_W-1:0]     port_sel_r;
  logic [NUM_LINES-1:0]           levels_now;
  edge_cfg_t                      edge_cfg;
  out_item_t                      result;
  line_state_t                    state;

  // Handshake between the two registers.
  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_en_r  <= '0;
      fall_en_r  <= '0;
      port_sel_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RISE:    rise_en_r  <= cfg_wdata[NUM_LINES-1:0];
        CFG_FALL:    fall_en_r  <= cfg_wdata[NUM_LINES-1:0];
        CFG_PORTSEL: port_sel_r <= cfg_wdata[NUM_LINES*SEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign edge_cfg.rise = rise_en_r;
  assign edge_cfg.fall = fall_en_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  eiec_sample #(
    .NUM_PORTS (NUM_PORTS)
  ) u_sample (
    .port_select (port_sel_r),
    .pin_levels  (s1_item_r.pin_levels),
    .levels      (levels_now)
  );

  eiec_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_move),
    .item       (s1_item_r),
    .levels_now (levels_now),
    .edge_cfg   (edge_cfg),
    .result     (result),
    .state      (state)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= result;
    end
  end

`include "external_interrupt_edge_controller_core_assert.svh"

  // A single-line request never fires without its pending bit.
  `EIEC_ASSERT_IMPLY(a_irq_has_pending, out_valid, ((out_data.irq_requests[SINGLE_LINES-1:0] & ~out_data.pending_lines[SINGLE_LINES-1:0]) == '0))

  // Pending bits only drop through a pending-register write.
  `EIEC_ASSERT_NEXT(a_pending_sticky, !(s1_move && s1_item_r.mode == MODE_WRITE && s1_item_r.reg_select == REG_PEND), ((state.pending & $past(state.pending)) == $past(state.pending)))

  // A held result with a full input register must stall the input.
  `EIEC_ASSERT_IMPLY(a_stall_when_full, s1_valid_r && out_valid && out_stall, in_stall)

endmodule

`default_nettype wire
